@@ rtl/bclp_pkg.sv @@
// shared types and constants of the button click and long press detector
`default_nettype none

package bclp_pkg;

  // field widths fixed by the item formats
  localparam int MAX_BUTTONS = 4;
  localparam int BTN_W       = 2;
  localparam int EV_W        = 2;
  localparam int DUR_W       = 32;
  localparam int NOW_W       = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  // item operation codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result event codes
  localparam logic [EV_W-1:0] EV_PRESSED       = 2'd0;
  localparam logic [EV_W-1:0] EV_CLICK         = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG_RELEASE  = 2'd2;
  localparam logic [EV_W-1:0] EV_LONG_DETECTED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b1;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;

  // result request from the qualifier to the output stage
  typedef struct packed {
    logic                   valid;
    logic                   tick;
    logic [MAX_BUTTONS-1:0] mask;
    logic [BTN_W-1:0]       button;
    logic [EV_W-1:0]        event_res;
    logic [DUR_W-1:0]       duration_ms;
  } bclp_req_t;

endpackage

`default_nettype wire

@@ rtl/bclp_if.sv @@
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface bclp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [bclp_pkg::MAX_BUTTONS-1:0]    pending_mask;
  logic [bclp_pkg::MAX_BUTTONS-1:0]    levels;
  logic [bclp_pkg::NOW_W-1:0]          now_ms;

  modport source (output valid, operation, pending_mask, levels, now_ms, input ready);
  modport sink   (input valid, operation, pending_mask, levels, now_ms, output ready);
endinterface

interface bclp_out_if;
  logic                         valid;
  logic                         ready;
  logic [bclp_pkg::BTN_W-1:0]   button;
  logic [bclp_pkg::EV_W-1:0]    event_res;
  logic [bclp_pkg::DUR_W-1:0]   duration_ms;
  logic                         last;

  modport source (output valid, button, event_res, duration_ms, last, input ready);
  modport sink   (input valid, button, event_res, duration_ms, last, output ready);
endinterface

`default_nettype wire

@@ rtl/bclp_state.sv @@
// per-button state and the edge/tick qualification logic
`default_nettype none

module bclp_state #(
  parameter int NUM_BUTTONS = 4,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             go,
  input  wire logic                             operation,
  input  wire logic [bclp_pkg::MAX_BUTTONS-1:0] pending_mask,
  input  wire logic [bclp_pkg::MAX_BUTTONS-1:0] levels,
  input  wire logic [bclp_pkg::NOW_W-1:0]       now_ms,
  input  wire logic [bclp_pkg::CFG_W-1:0]       debounce_ms,
  input  wire logic [bclp_pkg::CFG_W-1:0]       long_press_ms,
  output bclp_pkg::bclp_req_t                   req
);

  // buttons beyond the mask width never see an edge, so they keep no state
  localparam int ACT = (NUM_BUTTONS < bclp_pkg::MAX_BUTTONS) ? NUM_BUTTONS
                                                              : bclp_pkg::MAX_BUTTONS;

  typedef logic [TIME_BITS-1:0] stamp_t;

  stamp_t           proc_r  [ACT];
  stamp_t           acc_r   [ACT];
  stamp_t           start_r [ACT];
  logic [ACT-1:0]   held_r;
  logic [ACT-1:0]   lr_r;

  // time values at the state width
  logic [TIME_BITS+bclp_pkg::NOW_W-1:0] now_wide;
  logic [TIME_BITS+bclp_pkg::CFG_W-1:0] deb_wide;
  logic [TIME_BITS+bclp_pkg::CFG_W-1:0] lp_wide;
  stamp_t now_w;
  stamp_t deb_w;
  stamp_t lp_w;

  assign now_wide = {{TIME_BITS{1'b0}}, now_ms};
  assign deb_wide = {{TIME_BITS{1'b0}}, debounce_ms};
  assign lp_wide  = {{TIME_BITS{1'b0}}, long_press_ms};
  assign now_w    = now_wide[TIME_BITS-1:0];
  assign deb_w    = deb_wide[TIME_BITS-1:0];
  assign lp_w     = lp_wide[TIME_BITS-1:0];

  logic           is_edge;
  logic [ACT-1:0] sel_oh;
  logic [ACT-1:0] rep;
  logic [ACT-1:0] deb_ok;
  logic [ACT-1:0] chg;
  logic [ACT-1:0] long_ok;
  logic [ACT-1:0] qual;
  logic [ACT-1:0] take;
  stamp_t         el [ACT];

  assign is_edge = (operation == bclp_pkg::OP_EDGE);

  // per-button lanes: lowest pending pick, repeat, debounce, level change, hold time
  always_comb begin
    logic found;
    stamp_t acc_el;
    found  = 1'b0;
    sel_oh = '0;
    acc_el = '0;
    for (int i = 0; i < ACT; i++) begin
      if (pending_mask[i] && !found) begin
        sel_oh[i] = 1'b1;
        found     = 1'b1;
      end
      acc_el     = now_w - acc_r[i];
      el[i]      = now_w - start_r[i];
      rep[i]     = (now_w == proc_r[i]);
      deb_ok[i]  = (acc_el >= deb_w);
      chg[i]     = (levels[i] != held_r[i]);
      long_ok[i] = (el[i] >= lp_w);
      qual[i]    = held_r[i] && !lr_r[i] && long_ok[i];
      take[i]    = sel_oh[i] && !rep[i] && deb_ok[i] && chg[i];
    end
  end

  // build the result request from the taken lane or the tick mask
  always_comb begin
    logic [TIME_BITS+bclp_pkg::DUR_W-1:0] dur_wide;
    dur_wide        = '0;
    req             = '0;
    req.tick        = !is_edge;
    req.valid       = go && (is_edge ? (|take) : (|qual));
    for (int i = 0; i < ACT; i++) begin
      req.mask[i] = qual[i];
      if (take[i]) begin
        dur_wide   = {{bclp_pkg::DUR_W{1'b0}}, el[i]};
        req.button = bclp_pkg::BTN_W'(i);
        if (levels[i]) begin
          req.event_res   = bclp_pkg::EV_PRESSED;
          req.duration_ms = '0;
        end else begin
          req.event_res   = long_ok[i] ? bclp_pkg::EV_LONG_RELEASE : bclp_pkg::EV_CLICK;
          req.duration_ms = dur_wide[bclp_pkg::DUR_W-1:0];
        end
      end
    end
  end

  // state update when the held request commits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ACT; i++) begin
        proc_r[i]  <= '0;
        acc_r[i]   <= '0;
        start_r[i] <= '0;
      end
      held_r <= '0;
      lr_r   <= '0;
    end else if (go) begin
      for (int i = 0; i < ACT; i++) begin
        if (is_edge) begin
          if (sel_oh[i] && !rep[i]) begin
            proc_r[i] <= now_w;
          end
          if (take[i]) begin
            acc_r[i]  <= now_w;
            held_r[i] <= levels[i];
            if (levels[i]) begin
              start_r[i] <= now_w;
              lr_r[i]    <= 1'b0;
            end
          end
        end else if (qual[i]) begin
          lr_r[i] <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bclp_emit.sv @@
// output register that presents the results of one request, lowest button first on ticks
`default_nettype none

module bclp_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  bclp_pkg::bclp_req_t req,
  output logic               free,
  bclp_out_if.source         out_ch
);

  logic                             busy_r;
  logic                             tick_r;
  logic [bclp_pkg::MAX_BUTTONS-1:0] mask_r;
  logic [bclp_pkg::BTN_W-1:0]       btn_r;
  logic [bclp_pkg::EV_W-1:0]        ev_r;
  logic [bclp_pkg::DUR_W-1:0]       dur_r;

  logic [bclp_pkg::BTN_W-1:0]       low_btn;
  logic [bclp_pkg::MAX_BUTTONS-1:0] mask_rest;
  logic                             single;
  logic                             last_w;
  logic                             fire;

  // lowest set bit of the tick mask
  always_comb begin
    logic found;
    found   = 1'b0;
    low_btn = '0;
    for (int i = 0; i < bclp_pkg::MAX_BUTTONS; i++) begin
      if (mask_r[i] && !found) begin
        low_btn = bclp_pkg::BTN_W'(i);
        found   = 1'b1;
      end
    end
  end

  assign mask_rest = mask_r & (mask_r - 1'b1);
  assign single    = (mask_rest == '0);
  assign last_w    = tick_r ? single : 1'b1;
  assign fire      = busy_r && out_ch.ready;
  assign free      = !busy_r || (out_ch.ready && last_w);

  // result channel
  assign out_ch.valid       = busy_r;
  assign out_ch.button      = tick_r ? low_btn : btn_r;
  assign out_ch.event_res   = tick_r ? bclp_pkg::EV_LONG_DETECTED : ev_r;
  assign out_ch.duration_ms = tick_r ? '0 : dur_r;
  assign out_ch.last        = last_w;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tick_r <= 1'b0;
      mask_r <= '0;
    end else if (req.valid) begin
      busy_r <= 1'b1;
      tick_r <= req.tick;
      mask_r <= req.mask;
    end else if (fire) begin
      mask_r <= mask_rest;
      if (last_w) begin
        busy_r <= 1'b0;
      end
    end
  end

  // payload of a single edge result
  always_ff @(posedge clk) begin
    if (req.valid) begin
      btn_r <= req.button;
      ev_r  <= req.event_res;
      dur_r <= req.duration_ms;
    end
  end

endmodule

`default_nettype wire

@@ rtl/button_click_long_press_detector.sv @@
// top level of the button click and long press detector
//
// Input channel in_ch carries edge and tick requests; result channel out_ch
// carries button, event code, duration and a last mark. Configuration is a
// plain write port: cfg_we with cfg_index 0 writes debounce_ms, index 1
// writes long_press_ms.
// An accepted request lands in an input register. Once the output register
// can take it, the qualifier reads it against the per-button state, updates
// the state and loads the output register, which presents the result on out_ch.
// Edge requests give at most one result and sustain one request per cycle
// while out_ch is ready. A tick that finds k held buttons past the
// long-press time occupies the output register until its k results are
// out, lowest button first; the output register is the limiting resource,
// so it takes no new request until the last result of the one before leaves.
// When out_ch stalls, the input register still takes one more request, and
// in_ch.ready drops only while that register is full and the output is busy.
// Reset clears all button state (released, nothing reported, stamps zero)
// and restores debounce_ms to 50 and long_press_ms to 500.
`default_nettype none

module button_click_long_press_detector #(
  parameter int NUM_BUTTONS = 4,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bclp_in_if.sink                             in_ch,
  bclp_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bclp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bclp_pkg::CFG_W-1:0]     cfg_data
);

  logic [bclp_pkg::CFG_W-1:0]       debounce_r;
  logic [bclp_pkg::CFG_W-1:0]       long_press_r;

  logic                             in_full_r;
  logic                             op_r;
  logic [bclp_pkg::MAX_BUTTONS-1:0] pend_r;
  logic [bclp_pkg::MAX_BUTTONS-1:0] lev_r;
  logic [bclp_pkg::NOW_W-1:0]       now_r;

  bclp_pkg::bclp_req_t              req;
  logic                             emit_free;
  logic                             go;
  logic                             in_take;

  assign go          = in_full_r && emit_free;
  assign in_ch.ready = !in_full_r || go;
  assign in_take     = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= bclp_pkg::DEBOUNCE_RST;
      long_press_r <= bclp_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bclp_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        bclp_pkg::CFG_LONG_PRESS: long_press_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_take) begin
      in_full_r <= 1'b1;
    end else if (go) begin
      in_full_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_ch.operation;
      pend_r <= in_ch.pending_mask;
      lev_r  <= in_ch.levels;
      now_r  <= in_ch.now_ms;
    end
  end

  // qualifier with per-button state
  bclp_state #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (go),
    .operation     (op_r),
    .pending_mask  (pend_r),
    .levels        (lev_r),
    .now_ms        (now_r),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_press_r),
    .req           (req)
  );

  // result output register
  bclp_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .free   (emit_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ tb/sv/bclp_result_checker.sv @@
// result checker for the button click and long press detector: predicts and compares
module bclp_result_checker
  import bclp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bclp_in_if                   in_ch,
  bclp_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   results_due,
  output int                   results_seen
);

  // one expected result item
  typedef struct packed {
    logic [BTN_W-1:0] button;
    logic [EV_W-1:0]  event_res;
    logic [DUR_W-1:0] duration_ms;
    logic             last;
  } btn_result_t;

  // predicted button state and settings
  logic [NOW_W-1:0] seen_stamp  [MAX_BUTTONS];
  logic [NOW_W-1:0] taken_stamp [MAX_BUTTONS];
  logic [NOW_W-1:0] press_at    [MAX_BUTTONS];
  logic             is_held     [MAX_BUTTONS];
  logic             long_told   [MAX_BUTTONS];
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] long_ms;

  btn_result_t due_events[$];
  btn_result_t got;
  int          errors = 0;
  int          checked = 0;

  // compare one field of a result
  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // work out the results of one accepted request and queue them
  task automatic qualify_request(input logic op, input logic [MAX_BUTTONS-1:0] pend,
                                 input logic [MAX_BUTTONS-1:0] lev,
                                 input logic [NOW_W-1:0] now);
    int               hit;
    int               n;
    logic [NOW_W-1:0] span;
    btn_result_t      res;
    btn_result_t      found [MAX_BUTTONS];
    hit = -1;
    n   = 0;
    if (op == OP_EDGE) begin
      // lowest pending button only
      for (int b = MAX_BUTTONS - 1; b >= 0; b--)
        if (pend[b]) hit = b;
      if (hit < 0) return;
      if (now == seen_stamp[hit]) return;
      seen_stamp[hit] = now;
      span = now - taken_stamp[hit];
      if (span < NOW_W'(debounce_ms)) return;
      if (lev[hit] == is_held[hit]) return;
      taken_stamp[hit] = now;
      is_held[hit]     = lev[hit];
      res.button = BTN_W'(hit);
      res.last   = 1'b1;
      if (lev[hit]) begin
        press_at[hit]  = now;
        long_told[hit] = 1'b0;
        res.event_res   = EV_PRESSED;
        res.duration_ms = '0;
      end else begin
        span = now - press_at[hit];
        res.event_res   = (span < NOW_W'(long_ms)) ? EV_CLICK : EV_LONG_RELEASE;
        res.duration_ms = span;
      end
      due_events.push_back(res);
    end else begin
      // tick: every held button past the long-press time, lowest first
      for (int b = 0; b < MAX_BUTTONS; b++) begin
        span = now - press_at[b];
        if (is_held[b] && !long_told[b] && span >= NOW_W'(long_ms)) begin
          long_told[b]         = 1'b1;
          found[n].button      = BTN_W'(b);
          found[n].event_res   = EV_LONG_DETECTED;
          found[n].duration_ms = '0;
          found[n].last        = 1'b0;
          n++;
        end
      end
      for (int k = 0; k < n; k++) begin
        res      = found[k];
        res.last = (k == n - 1);
        due_events.push_back(res);
      end
    end
  endtask

  // watch the channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MAX_BUTTONS; b++) begin
        seen_stamp[b]  = '0;
        taken_stamp[b] = '0;
        press_at[b]    = '0;
        is_held[b]     = 1'b0;
        long_told[b]   = 1'b0;
      end
      debounce_ms = DEBOUNCE_RST;
      long_ms     = LONG_PRESS_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEBOUNCE) debounce_ms = cfg_data;
        else if (cfg_index == CFG_LONG_PRESS) long_ms = cfg_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_events.size() == 0) begin
          $error("result for button %0d event %0d with nothing expected",
                 out_ch.button, out_ch.event_res);
          errors++;
        end else begin
          got = due_events.pop_front();
          check_field("button", 32'(got.button), 32'(out_ch.button));
          check_field("event_res", 32'(got.event_res), 32'(out_ch.event_res));
          check_field("duration_ms", got.duration_ms, out_ch.duration_ms);
          check_field("last", 32'(got.last), 32'(out_ch.last));
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        qualify_request(in_ch.operation, in_ch.pending_mask, in_ch.levels, in_ch.now_ms);
    end
    results_due  <= due_events.size();
    fail_count   <= errors;
    results_seen <= checked;
  end

endmodule

@@ tb/sv/button_click_long_press_detector_tb.sv @@
// testbench top of the button click and long press detector: stimulus and verdict
module button_click_long_press_detector_tb;
  import bclp_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   results_due;
  int                   results_seen;

  // stimulus bookkeeping
  logic                   gaps_on = 1'b1;
  logic [CFG_W-1:0]       db_set = DEBOUNCE_RST;
  logic [CFG_W-1:0]       lp_set = LONG_PRESS_RST;
  logic [NOW_W-1:0]       clock_ms;
  logic [MAX_BUTTONS-1:0] btn_level = '0;
  int                     edge_reqs = 0;
  int                     tick_reqs = 0;
  int                     settings_used = 1;

  bclp_in_if  in_ch();
  bclp_out_if out_ch();

  always #5 clk = ~clk;

  button_click_long_press_detector u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  bclp_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due),
    .results_seen(results_seen)
  );

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= !gaps_on || ($urandom_range(99) >= 34);
  end

  // offer one request and hold it until accepted
  task automatic send_request(input logic op, input logic [MAX_BUTTONS-1:0] pend,
                              input logic [MAX_BUTTONS-1:0] lev,
                              input logic [NOW_W-1:0] now);
    while (gaps_on && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.pending_mask <= pend;
    in_ch.levels       <= lev;
    in_ch.now_ms       <= now;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_EDGE) edge_reqs++;
    else tick_reqs++;
  endtask

  // drop valid and wait until every expected result is out
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both timing registers back to back
  task automatic load_settings(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= db;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= lp;
    @(posedge clk);
    cfg_we <= 1'b0;
    db_set = db;
    lp_set = lp;
    settings_used++;
  endtask

  // time advance scaled to the current debounce and long-press settings
  function automatic logic [NOW_W-1:0] next_step();
    case ($urandom_range(7))
      0:          return '0;
      1, 2:       return NOW_W'($urandom_range(int'(db_set) + 1));
      3, 4, 5, 6: return NOW_W'($urandom_range(2 * int'(lp_set) + 2));
      default:    return NOW_W'($urandom);
    endcase
  endfunction

  // mostly toggles of one button, some ticks, some noise
  task automatic random_phase(input int count);
    int                     pick;
    int                     b;
    logic [MAX_BUTTONS-1:0] pend;
    clock_ms = NOW_W'($urandom);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      clock_ms += next_step();
      if (pick < 25) begin
        send_request(OP_TICK, 4'($urandom), 4'($urandom), clock_ms);
      end else if (pick < 85) begin
        b = $urandom_range(MAX_BUTTONS - 1);
        btn_level[b] = !btn_level[b];
        pend = (4'b1 << b) | (4'($urandom) & (4'hE << b));
        send_request(OP_EDGE, pend, btn_level, clock_ms);
      end else begin
        send_request(OP_EDGE, 4'($urandom), 4'($urandom),
                     ($urandom_range(1) != 0) ? clock_ms : NOW_W'($urandom));
      end
    end
  endtask

  // run limit
  initial begin
    #3000000;
    $display("button_click_long_press_detector_tb failed");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_EDGE;
    in_ch.pending_mask <= '0;
    in_ch.levels       <= '0;
    in_ch.now_ms       <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_DEBOUNCE;
    cfg_data           <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings 50 / 500
    send_request(OP_EDGE, 4'h0, 4'hF, 32'd100);        // empty mask
    send_request(OP_EDGE, 4'h1, 4'h1, 32'd0);          // stamp equal to reset stamp
    send_request(OP_EDGE, 4'h1, 4'h1, 32'd20);         // debounced against reset
    send_request(OP_EDGE, 4'h1, 4'h1, 32'd20);         // same stamp repeat
    send_request(OP_EDGE, 4'h1, 4'h1, 32'd100);        // press b0
    send_request(OP_EDGE, 4'h1, 4'h1, 32'd200);        // unchanged level
    send_request(OP_EDGE, 4'h6, 4'h6, 32'd300);        // lowest of two pending
    send_request(OP_EDGE, 4'hC, 4'hF, 32'd310);        // press b2
    send_request(OP_EDGE, 4'h8, 4'h8, 32'd320);        // press b3
    send_request(OP_TICK, 4'h0, 4'h0, 32'd400);        // nothing long yet
    send_request(OP_TICK, 4'hF, 4'hF, 32'd900);        // all four long
    send_request(OP_TICK, 4'h0, 4'h0, 32'd1000);       // already reported
    send_request(OP_EDGE, 4'h1, 4'h0, 32'd1100);       // long release b0
    send_request(OP_EDGE, 4'h2, 4'h0, 32'd1120);       // long release b1
    send_request(OP_EDGE, 4'h4, 4'h0, 32'd340);        // release inside debounce
    send_request(OP_EDGE, 4'h4, 4'h0, 32'd700);        // click b2
    send_request(OP_EDGE, 4'h4, 4'h4, 32'd750);        // debounce exactly met
    send_request(OP_EDGE, 4'h2, 4'h2, 32'd2000);       // press b1
    send_request(OP_EDGE, 4'h2, 4'h0, 32'd2500);       // duration exactly long
    send_request(OP_EDGE, 4'h1, 4'h1, 32'hFFFF_FFF0);  // press near wrap
    send_request(OP_EDGE, 4'h1, 4'h0, 32'h0000_0100);  // release across wrap
    send_request(OP_EDGE, 4'h8, 4'h0, 32'hFFFF_FFFF);  // very long release b3
    send_request(OP_TICK, 4'hF, 4'hF, 32'hFFFF_FFFF);  // b2 long at top of range
    settle_idle();

    // random phases over several settings
    random_phase(55);
    settle_idle();
    gaps_on <= 1'b0;
    load_settings(16'd0, 16'd0);
    random_phase(50);
    settle_idle();
    gaps_on <= 1'b1;
    load_settings(16'hFFFF, 16'hFFFF);
    random_phase(45);
    settle_idle();
    load_settings(16'($urandom_range(200)), 16'($urandom_range(2000)));
    random_phase(50);
    settle_idle();
    load_settings(16'hFFFF, 16'd0);
    random_phase(35);
    settle_idle();
    load_settings(16'd0, 16'hFFFF);
    random_phase(35);
    settle_idle();

    $display("covered %0d edge and %0d tick requests under %0d timing settings",
             edge_reqs, tick_reqs, settings_used);
    $display("compared %0d result items with the prediction", results_seen);
    if (fail_count == 0) begin
      $display("button_click_long_press_detector_tb passed");
    end else begin
      $display("button_click_long_press_detector_tb failed");
    end
    $finish;
  end

endmodule
